// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== sv/mat_pkg.sv =====
// ---------------------------------------------------------------------------
// mat_pkg
// types and constants of the mac address allow table
// ---------------------------------------------------------------------------
package mat_pkg;

  localparam int MAC_W   = 48;
  localparam int TOTAL_W = 5;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_PRESENT   = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN_RD,
    FSM_SCAN_CMP,
    FSM_SHIFT_RD,
    FSM_SHIFT_WR,
    FSM_RESP
  } fsm_t;

endpackage

// ===== sv/mat_ram.sv =====
// ---------------------------------------------------------------------------
// mat_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module mat_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/mac_address_allow_table.sv =====
// ---------------------------------------------------------------------------
// mac_address_allow_table
// insertion ordered table of 48-bit addresses: lookup, add, remove, clear
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   req_type, mac_addr
//   out      output     out_valid / out_ready ok, status, entry_total
//
// one item at a time; the scan reads each entry from the ram, then compares it
// remove: scan to the hit, then each later entry is read and written one place down
// the result sits in an output register; a new item is taken while it waits
// reset clears the count and the control state; ram contents are not cleared
// ---------------------------------------------------------------------------
module mac_address_allow_table #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic [mat_pkg::MAC_W-1:0]     mac_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [1:0]                    status,
  output logic [mat_pkg::TOTAL_W-1:0]   entry_total
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  mat_pkg::fsm_t              state, state_next;
  mat_pkg::req_t              req, req_next;
  mat_pkg::status_t           res_status, res_status_next;
  logic                       res_ok, res_ok_next;
  logic [mat_pkg::MAC_W-1:0]  addr, addr_next;
  logic [IW-1:0]              idx, idx_next;
  logic [CW-1:0]              count, count_next;
  logic [CW-1:0]              idx_inc;
  logic                       last;
  logic                       load;

  logic                       wr_en;
  logic [IW-1:0]              wr_addr;
  logic [mat_pkg::MAC_W-1:0]  wr_data;
  logic [IW-1:0]              rd_addr;
  logic [mat_pkg::MAC_W-1:0]  rd_data;

  mat_ram #(
    .WIDTH (mat_pkg::MAC_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign idx_inc  = CW'(idx) + CW'(1);
  assign last     = (idx_inc >= count);
  assign in_ready = (state == mat_pkg::FSM_IDLE);

  always_comb begin
    state_next      = state;
    req_next        = req;
    addr_next       = addr;
    idx_next        = idx;
    count_next      = count;
    res_ok_next     = res_ok;
    res_status_next = res_status;
    rd_addr         = idx;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = addr;
    load            = 1'b0;
    unique case (state)
      mat_pkg::FSM_IDLE: begin
        if (in_valid) begin
          req_next  = mat_pkg::req_t'(req_type);
          addr_next = mac_addr;
          idx_next  = '0;
          unique case (mat_pkg::req_t'(req_type))
            mat_pkg::REQ_CLEAR: begin
              count_next      = '0;
              res_ok_next     = 1'b1;
              res_status_next = mat_pkg::STAT_OK;
              state_next      = mat_pkg::FSM_RESP;
            end
            mat_pkg::REQ_ADD: begin
              if (count == CW'(TABLE_DEPTH)) begin
                res_ok_next     = 1'b0;
                res_status_next = mat_pkg::STAT_FULL;
                state_next      = mat_pkg::FSM_RESP;
              end else if (count == '0) begin
                wr_en           = 1'b1;
                wr_addr         = count[IW-1:0];
                wr_data         = mac_addr;
                count_next      = count + CW'(1);
                res_ok_next     = 1'b1;
                res_status_next = mat_pkg::STAT_OK;
                state_next      = mat_pkg::FSM_RESP;
              end else begin
                state_next = mat_pkg::FSM_SCAN_RD;
              end
            end
            default: begin
              if (count == '0) begin
                res_ok_next     = 1'b0;
                res_status_next = mat_pkg::STAT_NOT_FOUND;
                state_next      = mat_pkg::FSM_RESP;
              end else begin
                state_next = mat_pkg::FSM_SCAN_RD;
              end
            end
          endcase
        end
      end
      mat_pkg::FSM_SCAN_RD: begin
        rd_addr    = idx;
        state_next = mat_pkg::FSM_SCAN_CMP;
      end
      mat_pkg::FSM_SCAN_CMP: begin
        if (rd_data == addr) begin
          unique case (req)
            mat_pkg::REQ_LOOKUP: begin
              res_ok_next     = 1'b1;
              res_status_next = mat_pkg::STAT_OK;
              state_next      = mat_pkg::FSM_RESP;
            end
            mat_pkg::REQ_ADD: begin
              res_ok_next     = 1'b0;
              res_status_next = mat_pkg::STAT_PRESENT;
              state_next      = mat_pkg::FSM_RESP;
            end
            mat_pkg::REQ_REMOVE: begin
              state_next = mat_pkg::FSM_SHIFT_RD;
            end
            default: begin
              state_next = mat_pkg::FSM_RESP;
            end
          endcase
        end else if (last) begin
          if (req == mat_pkg::REQ_ADD) begin
            wr_en           = 1'b1;
            wr_addr         = count[IW-1:0];
            wr_data         = addr;
            count_next      = count + CW'(1);
            res_ok_next     = 1'b1;
            res_status_next = mat_pkg::STAT_OK;
          end else begin
            res_ok_next     = 1'b0;
            res_status_next = mat_pkg::STAT_NOT_FOUND;
          end
          state_next = mat_pkg::FSM_RESP;
        end else begin
          idx_next   = idx_inc[IW-1:0];
          state_next = mat_pkg::FSM_SCAN_RD;
        end
      end
      mat_pkg::FSM_SHIFT_RD: begin
        if (last) begin
          count_next      = count - CW'(1);
          res_ok_next     = 1'b1;
          res_status_next = mat_pkg::STAT_OK;
          state_next      = mat_pkg::FSM_RESP;
        end else begin
          rd_addr    = idx_inc[IW-1:0];
          state_next = mat_pkg::FSM_SHIFT_WR;
        end
      end
      mat_pkg::FSM_SHIFT_WR: begin
        wr_en      = 1'b1;
        wr_addr    = idx;
        wr_data    = rd_data;
        idx_next   = idx_inc[IW-1:0];
        state_next = mat_pkg::FSM_SHIFT_RD;
      end
      mat_pkg::FSM_RESP: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = mat_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = mat_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mat_pkg::FSM_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    addr       <= addr_next;
    idx        <= idx_next;
    res_ok     <= res_ok_next;
    res_status <= res_status_next;
    if (load) begin
      ok          <= res_ok;
      status      <= res_status;
      entry_total <= mat_pkg::TOTAL_W'(count);
    end
  end

endmodule

// ===== sv/mat_checker.sv =====
// ---------------------------------------------------------------------------
// mat_checker
// port level checks of the mac address allow table
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mat_checker #(
  parameter int TABLE_DEPTH = 16
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        ok,
  input logic [1:0]                  status,
  input logic [mat_pkg::TOTAL_W-1:0] entry_total
);

  // a stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(status) && $stable(entry_total), "stalled result changed")

  // ok is set exactly when status reports success
  `ASSERT_NEVER(a_ok_status, clk, rst, out_valid && (ok != (status == mat_pkg::STAT_OK)), "ok disagrees with status")

  // full is only reported at full depth
  `ASSERT_CLK(a_full_count, clk, rst, out_valid && status == mat_pkg::STAT_FULL |-> entry_total == mat_pkg::TOTAL_W'(TABLE_DEPTH), "full reported below depth")

  // one item at a time
  `ASSERT_CLK(a_one_item, clk, rst, in_valid && in_ready |=> !in_ready, "item taken while busy")

endmodule

bind mac_address_allow_table mat_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_mat_checker (.*);
